/* rtl/core/skvt_pkg.sv */
package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [VALUE_W-1:0] MISSING_RESET = 32'hFFFF_FC19;   // -999

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LOOKUP = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic search;   // capture compare result this cycle
        logic occ;      // cell lies below the entry count
        logic ins;      // load the new pair
        logic shift;    // take the neighbor's pair
    } t_cell_ctl;

endpackage

/* rtl/core/skvt_cell.sv */
module skvt_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skvt_pkg::t_cell_ctl               i_ctl,
    input  logic [skvt_pkg::KEY_W-1:0]        i_key,
    input  logic [skvt_pkg::VALUE_W-1:0]      i_value,
    input  logic [skvt_pkg::KEY_W-1:0]        i_next_key,
    input  logic [skvt_pkg::VALUE_W-1:0]      i_next_value,
    output logic [skvt_pkg::KEY_W-1:0]        o_key,
    output logic [skvt_pkg::VALUE_W-1:0]      o_value,
    output logic                              o_hit
);

    logic [skvt_pkg::KEY_W-1:0]   r_key, n_key;
    logic [skvt_pkg::VALUE_W-1:0] r_value, n_value;
    logic                         r_hit, n_hit;

    always_comb begin
        n_hit = i_ctl.search ? (i_ctl.occ && (r_key == i_key)) : r_hit;
        priority if (i_ctl.ins) begin
            n_key   = i_key;
            n_value = i_value;
        end else if (i_ctl.shift) begin
            n_key   = i_next_key;
            n_value = i_next_value;
        end else begin
            n_key   = r_key;
            n_value = r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_hit   = r_hit;

endmodule

/* rtl/core/small_key_value_table.sv */
// Small key/value table, kept in insertion order.
//
// Input channel: i_in_valid / o_in_stall carry one word of i_kind, i_key and
// i_value (insert, delete or lookup). Output channel: o_out_valid /
// i_out_stall carry one result word per input word: o_found, o_read_value,
// o_entry_count, o_is_full, o_is_empty. A word moves on an edge where valid
// is high and stall is low.
// The table is a row of CAPACITY cells. Each cell holds one pair and compares
// its key against the search key; on a delete, the cells from the deleted
// position up take the pair of their upper neighbor, so the row closes up at once.
// The result passes the search state (the cells register their compares) and
// the update state, and is then registered in the output register.
// A new word is taken in idle or in the update state of the current one, as
// that one commits; no word is taken during the search.
// If the receiver stalls, the finished result sits in the output register;
// a following word is still taken and searched, and its update waits until
// the output register frees up.
// Reset (synchronous, active low) empties the table and sets the missing
// value to -999. i_cfg_we writes i_cfg_data as the missing value; write it
// only while no word is in flight.
module small_key_value_table #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [skvt_pkg::VALUE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [skvt_pkg::KIND_W-1:0]   i_kind,
    input  logic [skvt_pkg::KEY_W-1:0]    i_key,
    input  logic [skvt_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [skvt_pkg::VALUE_W-1:0]  o_read_value,
    output logic [skvt_pkg::COUNT_W-1:0]  o_entry_count,
    output logic                          o_is_full,
    output logic                          o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // Control state
    skvt_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [skvt_pkg::VALUE_W-1:0] r_missing;
    logic             r_out_valid;

    // Operation under work
    logic [skvt_pkg::KIND_W-1:0]  r_kind;
    logic [skvt_pkg::KEY_W-1:0]   r_key;
    logic [skvt_pkg::VALUE_W-1:0] r_value;

    // Output register payload
    logic                          r_found;
    logic [skvt_pkg::VALUE_W-1:0]  r_read_value;
    logic [CW-1:0]                 r_res_count;

    logic accept, out_free, commit;

    // Cell row
    skvt_pkg::t_cell_ctl          ctl   [CAPACITY];
    logic [skvt_pkg::KEY_W-1:0]   c_key [CAPACITY];
    logic [skvt_pkg::VALUE_W-1:0] c_val [CAPACITY];
    logic [CAPACITY-1:0]          hits;

    // Resolve results of the compare cycle
    logic                          present;
    logic [IW-1:0]                 pos;
    logic [skvt_pkg::VALUE_W-1:0]  hit_value;
    logic                          ins_ok, del_ok;
    logic [skvt_pkg::VALUE_W-1:0]  n_read_value;
    logic [CW+skvt_pkg::COUNT_W-1:0] res_wide;

    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;

    // Sequencer: idle, compare, update
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        commit     = 1'b0;
        unique case (r_state)
            skvt_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = skvt_pkg::ST_SEARCH;
                end
            end
            skvt_pkg::ST_SEARCH: begin
                n_state = skvt_pkg::ST_UPDATE;
            end
            skvt_pkg::ST_UPDATE: begin
                // hold here until the output register can take the result
                if (out_free) begin
                    commit     = 1'b1;
                    o_in_stall = 1'b0;
                    n_state    = i_in_valid ? skvt_pkg::ST_SEARCH : skvt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::ST_IDLE;
            end
        endcase
    end

    // Reduce the hit row: keys are unique, so at most one cell hits
    always_comb begin
        present   = |hits;
        pos       = '0;
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (hits[i]) begin
                pos = pos | IW'(i);
            end
            hit_value = hit_value | (c_val[i] & {skvt_pkg::VALUE_W{hits[i]}});
        end
    end

    assign ins_ok = (r_kind == skvt_pkg::KIND_INSERT) && !present && (r_count < CAP_CNT);
    assign del_ok = (r_kind == skvt_pkg::KIND_DELETE) && present;

    always_comb begin
        n_count = r_count;
        if (commit && ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (commit && del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        if (r_kind == skvt_pkg::KIND_LOOKUP) begin
            n_read_value = present ? hit_value : r_missing;
        end else begin
            n_read_value = '0;
        end
    end

    // Per-cell control: compare in the search cycle, append or close up on commit
    generate
        for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
            localparam logic [IW-1:0] IDX    = IW'(g);
            localparam logic [CW-1:0] IDX_C  = CW'(g);
            localparam logic [CW:0]   NEXT_C = (CW + 1)'(g + 1);

            always_comb begin
                ctl[g].search = (r_state == skvt_pkg::ST_SEARCH);
                ctl[g].occ    = (IDX_C < r_count);
                ctl[g].ins    = commit && ins_ok && (IDX_C == r_count);
                ctl[g].shift  = commit && del_ok && (IDX >= pos)
                                && (NEXT_C < {1'b0, r_count});
            end

            if (g == CAPACITY - 1) begin : g_last
                skvt_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl[g]),
                    .i_key        (r_key),
                    .i_value      (r_value),
                    .i_next_key   (c_key[g]),
                    .i_next_value (c_val[g]),
                    .o_key        (c_key[g]),
                    .o_value      (c_val[g]),
                    .o_hit        (hits[g])
                );
            end else begin : g_mid
                skvt_cell u_cell (
                    .i_clk        (i_clk),
                    .i_rst_n      (i_rst_n),
                    .i_ctl        (ctl[g]),
                    .i_key        (r_key),
                    .i_value      (r_value),
                    .i_next_key   (c_key[g+1]),
                    .i_next_value (c_val[g+1]),
                    .o_key        (c_key[g]),
                    .o_value      (c_val[g]),
                    .o_hit        (hits[g])
                );
            end
        end
    endgenerate

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= skvt_pkg::ST_IDLE;
            r_count     <= '0;
            r_missing   <= skvt_pkg::MISSING_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_missing <= i_cfg_data;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: latch the operation, then the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (commit) begin
            r_found      <= present;
            r_read_value <= n_read_value;
            r_res_count  <= n_count;
        end
    end

    // Entry count field keeps its low bits only
    assign res_wide = {{skvt_pkg::COUNT_W{1'b0}}, r_res_count};

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_entry_count = res_wide[skvt_pkg::COUNT_W-1:0];
    assign o_is_full     = (r_res_count == CAP_CNT);
    assign o_is_empty    = (r_res_count == '0);

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::ST_UPDATE) |-> $onehot0(hits))
        else $error("key held in more than one cell");

    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> r_out_valid)
        else $error("result lost after update");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_count)) |-> ($past(r_state) == skvt_pkg::ST_UPDATE))
        else $error("entry count changed outside the update cycle");

endmodule
